@@ hw/rtl/sitrt_pkg.sv @@
// Shared types, constants and helpers for the signed integer to radix text block.
// No dependencies; every other file refers to this package by scoped names.
package sitrt_pkg;

   localparam int WORD_BITS  = 32;
   localparam int RADIX_W    = 6;
   localparam int CHAR_W     = 8;
   localparam int DIV_STEP   = 8;
   localparam int DIV_CYCLES = (WORD_BITS + DIV_STEP - 1) / DIV_STEP;
   localparam int DIV_W      = DIV_CYCLES * DIV_STEP;
   localparam int DCNT_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam int CNT_W      = $clog2(WORD_BITS + 1);
   localparam int ADDR_W     = $clog2(WORD_BITS);

   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] DIGIT_MAX = RADIX_W'(9);
   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0]  CHAR_A     = 8'h61;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0]  CHAR_Z     = 8'h7a;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] value;
      logic [RADIX_W-1:0]          radix;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] mag;
      logic                 neg;
      logic [RADIX_W-1:0]   radix;
   } job_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] wide;
      wide = CHAR_W'(d);
      if (d > DIGIT_MAX) begin
         return CHAR_A + wide - CHAR_W'(10);
      end
      return CHAR_ZERO + wide;
   endfunction

endpackage

@@ hw/rtl/signed_integer_to_radix_text.sv @@
// Top level of the signed integer to radix text converter.
// Depends on sitrt_pkg, sitrt_front, sitrt_job_queue and sitrt_back.
// Usage:
//   Input queue side: drive req_data (value, radix) and raise push; the item
//   is taken at a clock edge where push is high and full is low.
//   Result queue side: while empty is low, rsp_data holds the oldest waiting
//   character and its last flag; raise pop to take it.
//   Each item yields its text most significant character first, a leading
//   '-' for negative values, last set on the final character.
// Timing:
//   The front classifies in the accept cycle and parks the job in a
//   two-entry queue, so up to two items are taken while the back is busy.
//   The back divides 8 quotient bits per cycle and runs one full division
//   per digit, so the digit loop limits throughput.
//   Characters leave one per cycle while pop stays high.
// Reset and stalls:
//   Synchronous reset empties both queues and returns the back to idle; when
//   pop stays low the result queue fills, emission holds and full rises.
module signed_integer_to_radix_text (
   input  logic               clock,
   input  logic               reset,
   input  sitrt_pkg::req_type req_data,
   input  logic               push,
   output logic               full,
   output sitrt_pkg::rsp_type rsp_data,
   output logic               empty,
   input  logic               pop
);

   sitrt_pkg::job_type front_job;
   sitrt_pkg::job_type queued_job;
   logic               job_empty;
   logic               job_pop;

   // classify the incoming item: clamp the base, split sign and magnitude
   sitrt_front u_front (
      .req (req_data),
      .job (front_job)
   );

   // decouple accept from conversion
   sitrt_job_queue u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (push),
      .push_data (front_job),
      .is_full   (full),
      .pop_en    (job_pop),
      .pop_data  (queued_job),
      .is_empty  (job_empty)
   );

   // divide into digits, reverse and emit characters
   sitrt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (queued_job),
      .job_pop   (job_pop),
      .rsp_pop   (pop),
      .rsp       (rsp_data),
      .rsp_empty (empty)
   );

   // back must never take a job from an empty queue
   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !job_empty)
      else $error("job taken from empty queue");

   // every shown character is a sign, a decimal digit or a lower-case letter
   a_char_range : assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.character == sitrt_pkg::CHAR_MINUS ||
                  (rsp_data.character >= sitrt_pkg::CHAR_ZERO &&
                   rsp_data.character <= sitrt_pkg::CHAR_NINE) ||
                  (rsp_data.character >= sitrt_pkg::CHAR_A &&
                   rsp_data.character <= sitrt_pkg::CHAR_Z)))
      else $error("character out of range");

   // a minus sign is never the final character of a text
   a_sign_not_last : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.character == sitrt_pkg::CHAR_MINUS) |-> !rsp_data.last)
      else $error("sign marked last");

endmodule

@@ hw/rtl/sitrt_front.sv @@
// Front end: clamps the base and splits the value into sign and magnitude.
// Depends on sitrt_pkg.
module sitrt_front (
   input  sitrt_pkg::req_type req,
   output sitrt_pkg::job_type job
);

   logic                            neg;
   logic [sitrt_pkg::WORD_BITS-1:0] raw;

   assign raw = req.value;
   assign neg = raw[sitrt_pkg::WORD_BITS-1];

   always_comb begin
      job.neg = neg;
      // two's complement negate; the most negative value maps onto itself as unsigned
      job.mag = neg ? (~raw + sitrt_pkg::WORD_BITS'(1)) : raw;
      priority if (req.radix < sitrt_pkg::RADIX_MIN) begin
         job.radix = sitrt_pkg::RADIX_MIN;
      end else if (req.radix > sitrt_pkg::RADIX_MAX) begin
         job.radix = sitrt_pkg::RADIX_MAX;
      end else begin
         job.radix = req.radix;
      end
   end

endmodule

@@ hw/rtl/sitrt_job_queue.sv @@
// Two-entry queue of classified jobs between the front and back ends.
// Depends on sitrt_pkg.
module sitrt_job_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_en,
   input  sitrt_pkg::job_type push_data,
   output logic              is_full,
   input  logic              pop_en,
   output sitrt_pkg::job_type pop_data,
   output logic              is_empty
);

   sitrt_pkg::job_type entry_ff [0:1];
   logic               wr_ff;
   logic               rd_ff;
   logic [1:0]         cnt_ff;
   logic               do_push;
   logic               do_pop;

   assign is_full  = (cnt_ff == 2'd2);
   assign is_empty = (cnt_ff == 2'd0);
   assign do_push  = push_en && !is_full;
   assign do_pop   = pop_en && !is_empty;
   assign pop_data = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ff <= !wr_ff;
         end
         if (do_pop) begin
            rd_ff <= !rd_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/sitrt_back.sv @@
// Back end: digit divider, digit scratch memory, character emitter and result queue.
// Depends on sitrt_pkg.
module sitrt_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_empty,
   input  sitrt_pkg::job_type job,
   output logic              job_pop,
   input  logic              rsp_pop,
   output sitrt_pkg::rsp_type rsp,
   output logic              rsp_empty
);

   typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_EMIT} state_type;

   state_type                        state_ff;
   logic [sitrt_pkg::DIV_W-1:0]      quo_ff;
   logic [sitrt_pkg::RADIX_W-1:0]    rem_ff;
   logic [sitrt_pkg::RADIX_W-1:0]    radix_ff;
   logic [sitrt_pkg::DCNT_W-1:0]     dcyc_ff;
   logic [sitrt_pkg::CNT_W-1:0]      ndig_ff;
   logic                             neg_ff;
   logic                             em_sign_ff;
   logic [sitrt_pkg::CNT_W-1:0]      em_left_ff;
   logic                             issue_ff;
   logic                             issue_sign_ff;
   logic                             issue_last_ff;

   logic [sitrt_pkg::RADIX_W-1:0]    digit_ram_ff [0:sitrt_pkg::WORD_BITS-1];
   logic [sitrt_pkg::RADIX_W-1:0]    rd_data_ff;

   sitrt_pkg::rsp_type               oq_ff [0:1];
   logic                             oq_wr_ff;
   logic                             oq_rd_ff;
   logic [1:0]                       oq_cnt_ff;

   logic [sitrt_pkg::DIV_W-1:0]      quo_in;
   logic [sitrt_pkg::RADIX_W-1:0]    rem_in;
   logic                             last_step;
   logic                             div_done;
   logic                             wr_en;
   logic                             rd_en;
   logic [sitrt_pkg::CNT_W-1:0]      em_left_m1;
   logic                             oq_deq;
   logic [2:0]                       occ;
   logic                             issue_ok;
   sitrt_pkg::rsp_type               oq_push_data;

   // DIV_STEP restoring steps per cycle; remainder stays below the base
   always_comb begin
      logic [sitrt_pkg::RADIX_W:0]   t;
      logic [sitrt_pkg::RADIX_W-1:0] r;
      logic [sitrt_pkg::DIV_W-1:0]   q;
      r = rem_ff;
      q = quo_ff;
      for (int i = 0; i < sitrt_pkg::DIV_STEP; i++) begin
         t = {r, q[sitrt_pkg::DIV_W-1]};
         q = {q[sitrt_pkg::DIV_W-2:0], 1'b0};
         if (t >= {1'b0, radix_ff}) begin
            t    = t - {1'b0, radix_ff};
            q[0] = 1'b1;
         end
         r = t[sitrt_pkg::RADIX_W-1:0];
      end
      quo_in = q;
      rem_in = r;
   end

   assign last_step = (dcyc_ff == sitrt_pkg::DCNT_W'(sitrt_pkg::DIV_CYCLES - 1));
   assign div_done  = (quo_in == '0) || (ndig_ff == sitrt_pkg::CNT_W'(sitrt_pkg::WORD_BITS - 1));
   assign wr_en     = (state_ff == ST_DIVIDE) && last_step;
   assign job_pop   = (state_ff == ST_IDLE) && !job_empty;

   assign oq_deq    = rsp_pop && (oq_cnt_ff != 2'd0);
   assign occ       = {1'b0, oq_cnt_ff} + {2'b0, issue_ff} - {2'b0, oq_deq};
   assign issue_ok  = (occ < 3'd2);
   assign em_left_m1 = em_left_ff - sitrt_pkg::CNT_W'(1);
   assign rd_en     = (state_ff == ST_EMIT) && issue_ok && !em_sign_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_ff      <= 1'b0;
         issue_sign_ff <= 1'b0;
         issue_last_ff <= 1'b0;
         em_sign_ff    <= 1'b0;
         em_left_ff    <= '0;
         dcyc_ff       <= '0;
         ndig_ff       <= '0;
      end else begin
         issue_ff <= (state_ff == ST_EMIT) && issue_ok;
         unique case (state_ff)
            ST_IDLE: begin
               if (!job_empty) begin
                  quo_ff   <= sitrt_pkg::DIV_W'(job.mag);
                  rem_ff   <= '0;
                  radix_ff <= job.radix;
                  neg_ff   <= job.neg;
                  dcyc_ff  <= '0;
                  ndig_ff  <= '0;
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               quo_ff <= quo_in;
               if (last_step) begin
                  rem_ff  <= '0;
                  dcyc_ff <= '0;
                  ndig_ff <= ndig_ff + sitrt_pkg::CNT_W'(1);
                  if (div_done) begin
                     em_left_ff <= ndig_ff + sitrt_pkg::CNT_W'(1);
                     em_sign_ff <= neg_ff;
                     state_ff   <= ST_EMIT;
                  end
               end else begin
                  rem_ff  <= rem_in;
                  dcyc_ff <= dcyc_ff + sitrt_pkg::DCNT_W'(1);
               end
            end
            ST_EMIT: begin
               if (issue_ok) begin
                  if (em_sign_ff) begin
                     // sign leads; at least one digit always follows
                     em_sign_ff    <= 1'b0;
                     issue_sign_ff <= 1'b1;
                     issue_last_ff <= 1'b0;
                  end else begin
                     issue_sign_ff <= 1'b0;
                     issue_last_ff <= (em_left_ff == sitrt_pkg::CNT_W'(1));
                     em_left_ff    <= em_left_m1;
                     if (em_left_ff == sitrt_pkg::CNT_W'(1)) begin
                        state_ff <= ST_IDLE;
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // digit scratch: written least significant first, read back in reverse
   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_ram_ff[ndig_ff[sitrt_pkg::ADDR_W-1:0]] <= rem_in;
      end
      if (rd_en) begin
         rd_data_ff <= digit_ram_ff[em_left_m1[sitrt_pkg::ADDR_W-1:0]];
      end
   end

   always_comb begin
      oq_push_data.character = issue_sign_ff ? sitrt_pkg::CHAR_MINUS
                                             : sitrt_pkg::digit_char(rd_data_ff);
      oq_push_data.last      = issue_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         if (issue_ff) begin
            oq_wr_ff <= !oq_wr_ff;
         end
         if (oq_deq) begin
            oq_rd_ff <= !oq_rd_ff;
         end
         oq_cnt_ff <= oq_cnt_ff + {1'b0, issue_ff} - {1'b0, oq_deq};
      end
   end

   always_ff @(posedge clock) begin
      if (issue_ff) begin
         oq_ff[oq_wr_ff] <= oq_push_data;
      end
   end

   assign rsp       = oq_ff[oq_rd_ff];
   assign rsp_empty = (oq_cnt_ff == 2'd0);

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for signed_integer_to_radix_text: directed and random items.
// Depends on sitrt_pkg and the signed_integer_to_radix_text RTL; no other files.
`timescale 1ns / 100ps

module tb_top;

   // Cycles with no accepted item on either side before the run is declared hung.
   // The slowest item has 32 base-2 digits; even with the random idle bursts
   // on each side, this leaves wide margin.
   localparam int HANG_LIMIT = 2000;
   // Quiet cycles after the last expected character, to catch stray output.
   localparam int DRAIN_CYCLES = 200;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   sitrt_pkg::req_type req_data = '0;
   logic               push = 1'b0;
   logic               full;
   sitrt_pkg::rsp_type rsp_data;
   logic               empty;
   logic               pop = 1'b0;

   // Characters still owed by the block, oldest first.
   sitrt_pkg::rsp_type expected_chars[$];
   int                 failures = 0;
   int                 quiet_cycles = 0;
   int                 pop_stall_left = 0;
   // Random idling on both sides; cleared for the last part of the run.
   logic               idle_on = 1'b1;

   signed_integer_to_radix_text dut (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .push     (push),
      .full     (full),
      .rsp_data (rsp_data),
      .empty    (empty),
      .pop      (pop)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Work out the text of one value: digits least significant first from
   // repeated division, then put in front of each other so the most
   // significant character leaves first.
   function automatic void predict_text(input sitrt_pkg::req_type item);
      logic [sitrt_pkg::WORD_BITS-1:0] raw;
      logic [sitrt_pkg::WORD_BITS-1:0] mag;
      logic [sitrt_pkg::WORD_BITS-1:0] base;
      logic [sitrt_pkg::WORD_BITS-1:0] digit;
      logic                            neg;
      logic [7:0]                      text[$];
      sitrt_pkg::rsp_type              one;
      raw  = item.value;
      base = sitrt_pkg::WORD_BITS'(item.radix);
      // Clamp the base into 2..36.
      if (base < 2) begin
         base = 2;
      end
      if (base > 36) begin
         base = 36;
      end
      neg = raw[sitrt_pkg::WORD_BITS-1];
      // Magnitude as unsigned, so the most negative value does not overflow.
      mag = neg ? (~raw + 1'b1) : raw;
      do begin
         digit = mag % base;
         if (digit > 9) begin
            text.push_front(8'("a") + 8'(digit - 10));
         end else begin
            text.push_front(8'("0") + 8'(digit));
         end
         mag = mag / base;
      end while (mag != 0 && text.size() < sitrt_pkg::WORD_BITS);
      if (neg) begin
         text.push_front(8'("-"));
      end
      foreach (text[k]) begin
         one.character = text[k];
         one.last      = (k == text.size() - 1);
         expected_chars.push_back(one);
      end
   endfunction

   // Record each accepted item first, then check the character leaving on
   // the same edge; both are sampled from values that settled before the edge.
   always @(posedge clock) begin
      sitrt_pkg::rsp_type want;
      if (!reset) begin
         if (push && !full) begin
            predict_text(req_data);
         end
         if (pop && !empty) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected character %h (last %0b)", rsp_data.character,
                      rsp_data.last);
               failures++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.character !== want.character) begin
                  $error("character: expected %h, actual %h", want.character,
                         rsp_data.character);
                  failures++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_data.last);
                  failures++;
               end
            end
         end
      end
   end

   // Receiver: while idling is on, hold pop low for random bursts, else pop.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (!idle_on) begin
         pop <= 1'b1;
      end else if (pop_stall_left > 0) begin
         pop <= 1'b0;
         pop_stall_left = pop_stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         pop <= 1'b0;
         pop_stall_left = $urandom_range(1, 19) - 1;
      end else begin
         pop <= 1'b1;
      end
   end

   // Watchdog: end the run when no item moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Offer one item and return at the edge where it is accepted. Push stays
   // high afterwards, so back-to-back items need no drop in between.
   task automatic send_item(input logic [sitrt_pkg::WORD_BITS-1:0] value,
                            input logic [sitrt_pkg::RADIX_W-1:0] radix);
      sitrt_pkg::req_type item;
      int                 gap;
      item.value = value;
      item.radix = radix;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (full);
   endtask

   // Value extremes in the common bases, including the 33-character case.
   task automatic test_value_extremes();
      send_item(32'd0, 6'd10);
      send_item(32'd1, 6'd10);
      send_item(32'hffff_ffff, 6'd10);
      send_item(32'h7fff_ffff, 6'd10);
      send_item(32'h8000_0000, 6'd10);
      send_item(32'h8000_0000, 6'd2);
      send_item(32'h7fff_ffff, 6'd2);
      send_item(32'h8000_0000, 6'd36);
      send_item(32'h7fff_ffff, 6'd16);
      send_item(32'h8000_0000, 6'd16);
      send_item(32'hffff_ffff, 6'd2);
   endtask

   // Digit boundaries and bases outside 2..36 (clamped by the block).
   task automatic test_radix_edges();
      send_item(32'd35, 6'd36);           // single 'z'
      send_item(32'd10, 6'd11);           // single 'a'
      send_item(32'd9, 6'd10);            // single '9'
      send_item(-32'sd35, 6'd0);          // base 0 acts as 2
      send_item(32'd5, 6'd1);             // base 1 acts as 2
      send_item(32'd1295, 6'd37);         // base 37 acts as 36
      send_item(-32'sd100, 6'd63);        // base 63 acts as 36
      send_item(32'd12345, 6'd8);
      send_item(32'd255, 6'd16);
      send_item(32'hffff_ffff, 6'd36);
   endtask

   function automatic logic [sitrt_pkg::WORD_BITS-1:0] random_value();
      logic [sitrt_pkg::WORD_BITS-1:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = $urandom_range(0, 200);
         2: v = $urandom >> $urandom_range(0, 31);
         default: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'h7fff_ffff;
               2: v = 32'h0000_0000;
               default: v = 32'hffff_ffff;
            endcase
            v = v + $urandom_range(0, 4) - 2;
         end
      endcase
      // Flip the sign about half the time so short negative texts are common.
      if ($urandom_range(0, 1) == 1) begin
         v = ~v + 1'b1;
      end
      return v;
   endfunction

   function automatic logic [sitrt_pkg::RADIX_W-1:0] random_radix();
      if ($urandom_range(0, 6) == 0) begin
         return sitrt_pkg::RADIX_W'($urandom_range(0, 63));
      end
      return sitrt_pkg::RADIX_W'($urandom_range(2, 36));
   endfunction

   task automatic test_random_items(input int count);
      repeat (count) send_item(random_value(), random_radix());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_value_extremes();
      test_radix_edges();
      test_random_items(120);

      // Drop idling on both sides and run the last items back to back.
      idle_on <= 1'b0;
      test_random_items(30);

      push <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
